FILE: src/hamming_nearest_candidate_select_macros.svh
// assertion macros used by the checker of this block
`ifndef HAMMING_NEAREST_CANDIDATE_SELECT_MACROS_SVH
`define HAMMING_NEAREST_CANDIDATE_SELECT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define HNCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define HNCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/hncs_pkg.sv
`default_nettype none

package hncs_pkg;

	localparam int CODE_WORDS   = 8;
	localparam int QUERY_REGS   = 8;
	localparam int WORD_BITS    = 64;
	localparam int ID_BITS      = 20;
	localparam int WIDX_BITS    = 3;
	localparam int DIST_BITS    = 10;
	localparam int CNT_BITS     = 7;
	localparam int CFG_IDX_BITS = 3;

	typedef logic [WORD_BITS-1:0]    word_t;
	typedef logic [ID_BITS-1:0]      id_t;
	typedef logic [WIDX_BITS-1:0]    widx_t;
	typedef logic [DIST_BITS-1:0]    dist_t;
	typedef logic [CNT_BITS-1:0]     cnt_t;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	localparam dist_t MAX_DIST  = dist_t'(512);
	localparam widx_t CLOSE_IDX = widx_t'(CODE_WORDS - 1);

	// set bits of one byte
	function automatic logic [3:0] popcount8(input logic [7:0] b);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + {3'b000, b[i]};
		end
		return n;
	endfunction

	// set bits of a 64-bit word, as a sum of eight byte counts
	function automatic cnt_t popcount64(input word_t w);
		cnt_t n;
		n = '0;
		for (int k = 0; k < WORD_BITS / 8; k++) begin
			n = n + cnt_t'(popcount8(w[k*8 +: 8]));
		end
		return n;
	endfunction

endpackage

`default_nettype wire

FILE: src/hncs_ifs.sv
`default_nettype none

// candidate word channel
interface hncs_cand_if import hncs_pkg::*;;
	logic  valid;
	logic  ready;
	id_t   candidate_id;
	widx_t word_index;
	word_t code_word;
	logic  last_candidate;

	modport source (output valid, candidate_id, word_index, code_word, last_candidate,
		input ready);
	modport sink (input valid, candidate_id, word_index, code_word, last_candidate,
		output ready);
endinterface

// best-match result channel
interface hncs_result_if import hncs_pkg::*;;
	logic  valid;
	logic  ready;
	id_t   best_id;
	dist_t best_distance;

	modport source (output valid, best_id, best_distance, input ready);
	modport sink (input valid, best_id, best_distance, output ready);
endinterface

`default_nettype wire

FILE: src/hamming_nearest_candidate_select.sv
`default_nettype none

// Hamming nearest-candidate select: re-ranks a stream of binary candidate codes against a
// 512-bit query held in eight 64-bit registers (cfg index k holds query bits 64k..64k+63).
// Each item is one 64-bit word of a candidate with its id, word index and a last-candidate
// flag; words with index 7 close a candidate, and a closed candidate replaces the running
// best only when its distance is strictly lower (ties keep the earlier one). A closing word
// that carries the last flag produces one result item (best id, best distance; id 0 and
// distance 512 if nothing beat 512) and clears the search for the next set. The block takes
// one item per clock cycle when not held back: a popcount stage and an accumulate/compare
// stage sit behind an input register, and a result goes from there into an output register.
// Input is only held back when a result is stuck in the output register and the
// next result is already waiting behind it. Query registers may only be written while no
// items are in flight.
module hamming_nearest_candidate_select import hncs_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_we,
	input  wire cfg_idx_t cfg_index,
	input  wire word_t    cfg_data,
	hncs_cand_if.sink     cand,
	hncs_result_if.source result
);

	// query code
	word_t query_q [QUERY_REGS];

	// stage 1: registered input item
	logic  valid_s1;
	id_t   id_s1;
	widx_t widx_s1;
	word_t word_s1;
	logic  last_s1;

	// stage 2: word distance and closing flags
	logic  valid_s2;
	id_t   id_s2;
	cnt_t  cnt_s2;
	logic  close_s2;
	logic  last_s2;

	// search state
	dist_t run_q;
	dist_t best_q;
	id_t   best_id_q;

	// output register
	logic  out_valid_q;
	id_t   out_id_q;
	dist_t out_dist_q;

	logic                 emit_s2;
	logic                 commit_s2;
	logic                 s2_free;
	logic                 s1_free;
	logic                 in_take;
	logic                 in_range;
	logic [DIST_BITS:0]   sum;
	dist_t                new_run;
	logic                 win;
	dist_t                new_best;
	id_t                  new_best_id;

	// an item that raises a result can only leave stage 2 if the output register frees up
	assign emit_s2   = valid_s2 && close_s2 && last_s2;
	assign commit_s2 = valid_s2 && (!emit_s2 || !out_valid_q || result.ready);
	assign s2_free   = !valid_s2 || commit_s2;
	assign s1_free   = !valid_s1 || s2_free;
	assign cand.ready = s1_free;
	assign in_take   = cand.valid && s1_free;

	// words beyond the code length are dropped at the door
	assign in_range = {1'b0, cand.word_index} < (WIDX_BITS + 1)'(CODE_WORDS);

	// running distance, saturating at the code length
	always_comb begin
		sum = {1'b0, run_q} + (DIST_BITS + 1)'(cnt_s2);
		if (sum > {1'b0, MAX_DIST}) begin
			new_run = MAX_DIST;
		end else begin
			new_run = sum[DIST_BITS-1:0];
		end
		win = new_run < best_q;
		new_best    = win ? new_run : best_q;
		new_best_id = win ? id_s2 : best_id_q;
	end

	// query registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QUERY_REGS; k++) begin
				query_q[k] <= '0;
			end
		end else if (cfg_we) begin
			query_q[cfg_index] <= cfg_data;
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= cand.valid && in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			id_s1   <= cand.candidate_id;
			widx_s1 <= cand.word_index;
			word_s1 <= cand.code_word;
			last_s1 <= cand.last_candidate;
		end
	end

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	// xor against the matching query word and count the differing bits
	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			id_s2    <= id_s1;
			cnt_s2   <= popcount64(word_s1 ^ query_q[widx_s1]);
			close_s2 <= widx_s1 == CLOSE_IDX;
			last_s2  <= last_s1;
		end
	end

	// accumulate, compare on the closing word, clear after a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q     <= '0;
			best_q    <= MAX_DIST;
			best_id_q <= '0;
		end else if (commit_s2) begin
			if (!close_s2) begin
				run_q <= new_run;
			end else if (last_s2) begin
				run_q     <= '0;
				best_q    <= MAX_DIST;
				best_id_q <= '0;
			end else begin
				run_q     <= '0;
				best_q    <= new_best;
				best_id_q <= new_best_id;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit_s2 && emit_s2) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_s2 && emit_s2) begin
			out_id_q   <= new_best_id;
			out_dist_q <= new_best;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.best_id       = out_id_q;
	assign result.best_distance = out_dist_q;

endmodule

`default_nettype wire

FILE: src/hncs_checker.sv
`default_nettype none

`include "hamming_nearest_candidate_select_macros.svh"

module hncs_checker import hncs_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	input wire logic  out_valid,
	input wire logic  out_ready,
	input wire id_t   best_id,
	input wire dist_t best_distance
);

	// a stalled result holds its payload
	`HNCS_ASSERT_NXT(a_result_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(best_id) && $stable(best_distance), "result changed while stalled")

	// distance never exceeds the code length
	`HNCS_ASSERT_IMP(a_dist_range, clk, arst_n, out_valid, best_distance <= MAX_DIST, "best distance above code length")

	// no winner means the default id
	`HNCS_ASSERT_IMP(a_no_winner_id, clk, arst_n, out_valid && best_distance == MAX_DIST, best_id == '0, "id set without a winning candidate")

endmodule

bind hamming_nearest_candidate_select hncs_checker u_hncs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.best_id       (result.best_id),
	.best_distance (result.best_distance)
);

`default_nettype wire
